@@ hw/rtl/mexp_pkg.sv @@
// Shared definitions for the modular exponentiation block.
// Holds the operand width, the sequencer states and the multiplier interface types.
// No dependencies.
package mexp_pkg;

    // Width of the ports and width of the arithmetic.
    localparam int FIELD_W = 64;
    localparam int WIDTH   = 64;
    localparam int CNT_W   = $clog2(WIDTH);

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_DISPATCH,
        S_RMUL,
        S_BSQ,
        S_OUT
    } t_state;

    // Request from the sequencer to the modular multiplier.
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
    } t_mm_req;

    // Status from the modular multiplier back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage

@@ hw/rtl/mexp_mulmod.sv @@
// Bit-serial add-and-double modular multiplier: a * b mod m, one multiplier bit per cycle.
// Depends on mexp_pkg for the width and the request and status types.
module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mm_req          i_req,
    input  logic [WIDTH-1:0] i_mod,
    output t_mm_status       o_status,
    output logic [WIDTH-1:0] o_prod
);

    logic             r_run, n_run;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_a, n_a;
    logic [WIDTH-1:0] r_mul, n_mul;

    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] mod1;
    logic [WIDTH+1:0] mod2;
    logic [WIDTH+1:0] diff1;
    logic [WIDTH+1:0] diff2;
    logic [WIDTH-1:0] step;

    // One step: 2*acc plus a when the multiplier bit is set, then reduce.
    // With acc and a below m the sum stays below 3m, so at most 2m comes off.
    always_comb begin
        mod1  = {2'b00, i_mod};
        mod2  = {1'b0, i_mod, 1'b0};
        sum   = {1'b0, r_acc, 1'b0} + (r_mul[WIDTH-1] ? {2'b00, r_a} : '0);
        diff1 = sum - mod1;
        diff2 = sum - mod2;
        if (sum >= mod2) begin
            step = diff2[WIDTH-1:0];
        end else if (sum >= mod1) begin
            step = diff1[WIDTH-1:0];
        end else begin
            step = sum[WIDTH-1:0];
        end
    end

    // Next values: load on a request, otherwise walk the multiplier from its top bit.
    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_mul  = r_mul;
        if (i_req.start && !r_run) begin
            n_run = 1'b1;
            n_cnt = CNT_W'(WIDTH - 1);
            n_acc = '0;
            n_a   = i_req.a;
            n_mul = i_req.b;
        end else if (r_run) begin
            n_acc = step;
            n_mul = {r_mul[WIDTH-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
        r_mul <= n_mul;
    end

    assign o_status.busy = r_run;
    assign o_status.done = r_done;
    assign o_prod        = r_acc;

endmodule

@@ hw/rtl/modular_exponentiation_unit.sv @@
// Modular exponentiation block: base_value ** exponent mod modulus.
// Use: write the modulus on the cfg channel (i_cfg_valid / o_cfg_ready, i_cfg_modulus)
// while the block is idle; it resets to 1. An item is accepted on a rising edge with
// i_start high and o_busy low. o_busy stays high until the result has been shown.
// The result appears on o_power_result for exactly one cycle with o_result_valid high;
// the receiver cannot stall it and must take it in that cycle.
// The block works right to left over the exponent with one shared bit-serial modular
// multiplier. The base is first reduced by multiplying it by one. Each exponent bit
// costs a pass through the dispatch state, a squaring, and a multiply when the bit
// is set; work stops after the highest set bit.
// A zero modulus gives 0 in the cycle after accept. One item at a time: the next item
// can be taken at the end of the cycle that follows the strobe.
// Reset returns the sequencer to idle and the modulus to 1; an item at work is lost.
// Depends on mexp_pkg and mexp_mulmod.
module modular_exponentiation_unit
    import mexp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [FIELD_W-1:0] i_base_value,
    input  logic [FIELD_W-1:0] i_exponent,
    output logic               o_result_valid,
    output logic [FIELD_W-1:0] o_power_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [FIELD_W-1:0] i_cfg_modulus
);

    t_state           r_state, n_state;
    logic [FIELD_W-1:0] r_mod;
    logic [WIDTH-1:0] mod_w;
    logic [WIDTH-1:0] r_res, n_res;
    logic [WIDTH-1:0] r_sq, n_sq;
    logic [WIDTH-1:0] r_exp, n_exp;

    t_mm_req          mm_req;
    t_mm_status       mm_status;
    logic [WIDTH-1:0] mm_prod;

    assign mod_w = r_mod[WIDTH-1:0];

    // Shared modular multiplier.
    mexp_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mm_req),
        .i_mod    (mod_w),
        .o_status (mm_status),
        .o_prod   (mm_prod)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (mod_w == '0) ? S_OUT : S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (mm_status.done) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (r_exp == '0) begin
                    n_state = S_OUT;
                end else if (r_exp[0]) begin
                    n_state = S_RMUL;
                end else begin
                    n_state = S_BSQ;
                end
            end
            S_RMUL: begin
                if (mm_status.done) begin
                    n_state = S_BSQ;
                end
            end
            S_BSQ: begin
                if (mm_status.done) begin
                    n_state = S_DISPATCH;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: multiplier requests.
    always_comb begin
        mm_req.start = 1'b0;
        mm_req.a     = r_sq;
        mm_req.b     = r_sq;
        case (r_state)
            S_IDLE: begin
                mm_req.start = i_start && (mod_w != '0);
                mm_req.a     = WIDTH'(1);
                mm_req.b     = i_base_value[WIDTH-1:0];
            end
            S_DISPATCH: begin
                mm_req.start = (r_exp != '0);
                mm_req.a     = r_exp[0] ? r_res : r_sq;
            end
            S_RMUL: begin
                mm_req.start = mm_status.done;
            end
            default: begin
                mm_req.start = 1'b0;
            end
        endcase
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_cfg_ready    = (r_state == S_IDLE);
    assign o_result_valid = (r_state == S_OUT);
    assign o_power_result = FIELD_W'(r_res);

    // Working values: result, running square of the base and remaining exponent.
    always_comb begin
        n_res = r_res;
        n_sq  = r_sq;
        n_exp = r_exp;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_exp = i_exponent[WIDTH-1:0];
                    n_res = (mod_w == '0) ? '0 : WIDTH'(1);
                end
            end
            S_REDUCE: begin
                if (mm_status.done) begin
                    n_sq = mm_prod;
                end
            end
            S_RMUL: begin
                if (mm_status.done) begin
                    n_res = mm_prod;
                end
            end
            S_BSQ: begin
                if (mm_status.done) begin
                    n_sq  = mm_prod;
                    n_exp = r_exp >> 1;
                end
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    // Control state and the modulus register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mod   <= FIELD_W'(1);
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mod <= i_cfg_modulus;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_sq  <= n_sq;
        r_exp <= n_exp;
    end

    // The result strobe lasts a single cycle.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // A zero modulus gives its result right after the item is taken.
    a_zero_mod_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (mod_w == '0)) |=> o_result_valid)
        else $error("zero modulus item did not finish at once");

    // A result lies below the modulus, apart from a zero modulus and x**0 mod 1.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (((mod_w == '0) && (r_res == '0)) ||
                            ((mod_w != '0) && (r_res < mod_w)) ||
                            ((mod_w == WIDTH'(1)) && (r_res == WIDTH'(1)))))
        else $error("result out of range");

    // The multiplier is never asked to start while it runs.
    a_mm_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_req.start |-> !mm_status.busy)
        else $error("multiplier started while busy");

    // The multiplier only finishes while an item is at work.
    a_mm_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_status.done |-> o_busy)
        else $error("multiplier finished while idle");

endmodule
